### design/gn3_pkg.sv
// ----------------------------------------------------------------------------
// gn3_pkg
// Shared types, constants and the gradient function of the 3d noise pipeline.
// ----------------------------------------------------------------------------
package gn3_pkg;

  localparam int F   = 16;   // fractional bits of the coordinates
  localparam int IW  = 8;    // permutation table index bits
  localparam int NST = 9;    // pipeline stages

  typedef logic [IW-1:0]           idx_t;
  typedef logic [F-1:0]            frac_t;
  typedef logic [F+3:0]            fade_t;
  typedef logic [2*F+3:0]          fprod_t;
  typedef logic signed [F+1:0]     ofs_t;
  typedef logic signed [F+2:0]     grad_t;
  typedef logic signed [F+3:0]     diff_t;
  typedef logic signed [2*F+5:0]   lprod_t;
  typedef logic [3:0]              hash_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef struct packed {
    logic [NST:1] adv;   // stage k loads this cycle
    logic [NST:1] vld;   // stage k holds an item
  } stage_ctl_t;

  localparam fade_t FADE_15 = fade_t'(15) << F;
  localparam fade_t FADE_10 = fade_t'(10) << F;
  localparam ofs_t  OFS_ONE = ofs_t'(1) << F;

  function automatic grad_t corner_dot(hash_t h, ofs_t x, ofs_t y, ofs_t z);
    ofs_t  u;
    ofs_t  v;
    grad_t su;
    grad_t sv;
    u  = (h < 4'd8) ? x : y;
    v  = (h < 4'd4) ? y : (((h == 4'd12) || (h == 4'd14)) ? x : z);
    su = h[0] ? -grad_t'(u) : grad_t'(u);
    sv = h[1] ? -grad_t'(v) : grad_t'(v);
    return su + sv;
  endfunction

endpackage

### design/gn3_fade.sv
// ----------------------------------------------------------------------------
// gn3_fade
// Quintic fade 6t^5-15t^4+10t^3 over four multiply stages, one axis.
// ----------------------------------------------------------------------------
module gn3_fade (
  input  logic                clk,
  input  gn3_pkg::stage_ctl_t ctl,
  input  gn3_pkg::frac_t      t_in,
  output gn3_pkg::frac_t      t_s4,
  output gn3_pkg::fade_t      fade_s5
);

  gn3_pkg::frac_t  t1_r, t2_r, t3_r, t4_r;
  gn3_pkg::fprod_t prod2_r, prod3_r, prod4_r, prod5_r;
  gn3_pkg::fade_t  s_nxt, p0_nxt;

  always_comb begin
    s_nxt  = gn3_pkg::FADE_15 - (gn3_pkg::fade_t'({t1_r, 2'b00})
             + gn3_pkg::fade_t'({t1_r, 1'b0}));
    p0_nxt = gn3_pkg::FADE_10 - gn3_pkg::fade_t'(prod2_r >> gn3_pkg::F);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[1]) t1_r <= t_in;
    if (ctl.adv[2]) begin
      t2_r    <= t1_r;
      prod2_r <= gn3_pkg::fprod_t'(t1_r) * gn3_pkg::fprod_t'(s_nxt);
    end
    if (ctl.adv[3]) begin
      t3_r    <= t2_r;
      prod3_r <= gn3_pkg::fprod_t'(p0_nxt) * gn3_pkg::fprod_t'(t2_r);
    end
    if (ctl.adv[4]) begin
      t4_r    <= t3_r;
      prod4_r <= gn3_pkg::fprod_t'(gn3_pkg::fade_t'(prod3_r >> gn3_pkg::F))
                 * gn3_pkg::fprod_t'(t3_r);
    end
    if (ctl.adv[5]) begin
      prod5_r <= gn3_pkg::fprod_t'(gn3_pkg::fade_t'(prod4_r >> gn3_pkg::F))
                 * gn3_pkg::fprod_t'(t4_r);
    end
  end

  assign t_s4    = t4_r;
  assign fade_s5 = gn3_pkg::fade_t'(prod5_r >> gn3_pkg::F);

endmodule

### design/gn3_hash.sv
// ----------------------------------------------------------------------------
// gn3_hash
// Corner hashing through three levels of permutation table copies. Each copy
// is written by a load beat as it passes the stage that reads that copy.
// ----------------------------------------------------------------------------
module gn3_hash (
  input  logic                       clk,
  input  gn3_pkg::stage_ctl_t        ctl,
  input  logic                       op_in,
  input  gn3_pkg::idx_t              ld_idx,
  input  gn3_pkg::idx_t              ld_val,
  input  gn3_pkg::idx_t              cell_x,
  input  gn3_pkg::idx_t              cell_y,
  input  gn3_pkg::idx_t              cell_z,
  output logic                       op_s4,
  output logic [7:0][3:0]            hash_s4
);

  localparam int DEPTH = 1 << gn3_pkg::IW;
  localparam gn3_pkg::idx_t ONE_IDX = gn3_pkg::idx_t'(1);

  gn3_pkg::idx_t mem0 [DEPTH];
  gn3_pkg::idx_t mem1 [DEPTH];
  gn3_pkg::idx_t mem2 [DEPTH];
  gn3_pkg::idx_t mem3 [DEPTH];
  gn3_pkg::idx_t mem4 [DEPTH];
  gn3_pkg::idx_t mem5 [DEPTH];
  gn3_pkg::idx_t mem6 [DEPTH];

  logic          op1_r, op2_r, op3_r, op4_r;
  gn3_pkg::idx_t li1_r, lv1_r, li2_r, lv2_r, li3_r, lv3_r;
  gn3_pkg::idx_t ix1_r, iy1_r, iz1_r, iy2_r, iz2_r, iz3_r;
  gn3_pkg::idx_t pa2_r, pb2_r;
  gn3_pkg::idx_t paa3_r, pab3_r, pba3_r, pbb3_r;
  logic [7:0][3:0] h4_r;
  gn3_pkg::idx_t a_nxt, b_nxt, aa_nxt, ab_nxt, ba_nxt, bb_nxt;

  always_comb begin
    a_nxt  = pa2_r + iy2_r;
    b_nxt  = pb2_r + iy2_r;
    aa_nxt = paa3_r + iz3_r;
    ab_nxt = pab3_r + iz3_r;
    ba_nxt = pba3_r + iz3_r;
    bb_nxt = pbb3_r + iz3_r;
  end

  // table writes, one level per stage
  always_ff @(posedge clk) begin
    if (ctl.vld[1] && (op1_r == gn3_pkg::OP_LOAD)) mem0[li1_r] <= lv1_r;
    if (ctl.vld[2] && (op2_r == gn3_pkg::OP_LOAD)) begin
      mem1[li2_r] <= lv2_r;
      mem2[li2_r] <= lv2_r;
    end
    if (ctl.vld[3] && (op3_r == gn3_pkg::OP_LOAD)) begin
      mem3[li3_r] <= lv3_r;
      mem4[li3_r] <= lv3_r;
      mem5[li3_r] <= lv3_r;
      mem6[li3_r] <= lv3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[1]) begin
      op1_r <= op_in;
      li1_r <= ld_idx;
      lv1_r <= ld_val;
      ix1_r <= cell_x;
      iy1_r <= cell_y;
      iz1_r <= cell_z;
    end
    if (ctl.adv[2]) begin
      op2_r <= op1_r;
      li2_r <= li1_r;
      lv2_r <= lv1_r;
      iy2_r <= iy1_r;
      iz2_r <= iz1_r;
      pa2_r <= mem0[ix1_r];
      pb2_r <= mem0[ix1_r + ONE_IDX];
    end
    if (ctl.adv[3]) begin
      op3_r  <= op2_r;
      li3_r  <= li2_r;
      lv3_r  <= lv2_r;
      iz3_r  <= iz2_r;
      paa3_r <= mem1[a_nxt];
      pab3_r <= mem1[a_nxt + ONE_IDX];
      pba3_r <= mem2[b_nxt];
      pbb3_r <= mem2[b_nxt + ONE_IDX];
    end
    if (ctl.adv[4]) begin
      op4_r   <= op3_r;
      h4_r[0] <= mem3[aa_nxt][3:0];
      h4_r[4] <= mem3[aa_nxt + ONE_IDX][3:0];
      h4_r[2] <= mem4[ab_nxt][3:0];
      h4_r[6] <= mem4[ab_nxt + ONE_IDX][3:0];
      h4_r[1] <= mem5[ba_nxt][3:0];
      h4_r[5] <= mem5[ba_nxt + ONE_IDX][3:0];
      h4_r[3] <= mem6[bb_nxt][3:0];
      h4_r[7] <= mem6[bb_nxt + ONE_IDX][3:0];
    end
  end

  assign op_s4   = op4_r;
  assign hash_s4 = h4_r;

endmodule

### design/gn3_interp.sv
// ----------------------------------------------------------------------------
// gn3_interp
// Trilinear interpolation of the eight corner dots and output scaling.
// ----------------------------------------------------------------------------
module gn3_interp (
  input  logic                       clk,
  input  gn3_pkg::stage_ctl_t        ctl,
  input  gn3_pkg::grad_t             grad_s5 [8],
  input  gn3_pkg::fade_t             u_s5,
  input  gn3_pkg::fade_t             v_s5,
  input  gn3_pkg::fade_t             w_s5,
  output logic [15:0]                noise_s9
);

  localparam int QW = gn3_pkg::F + 19;

  gn3_pkg::grad_t  la6_r [4];
  gn3_pkg::lprod_t lp6_r [4];
  gn3_pkg::grad_t  ma7_r [2];
  gn3_pkg::lprod_t mp7_r [2];
  gn3_pkg::grad_t  za8_r;
  gn3_pkg::lprod_t zp8_r;
  gn3_pkg::fade_t  v6_r, w6_r, w7_r;
  logic [15:0]     noise9_r;

  gn3_pkg::grad_t  l1_nxt [4];
  gn3_pkg::grad_t  m_nxt [2];
  gn3_pkg::grad_t  r_nxt;
  gn3_pkg::grad_t  q_nxt;
  logic [QW-1:0]   sc_nxt;

  function automatic gn3_pkg::lprod_t lmul(gn3_pkg::fade_t t, gn3_pkg::grad_t a,
                                          gn3_pkg::grad_t b);
    gn3_pkg::diff_t d;
    d = gn3_pkg::diff_t'(b) - gn3_pkg::diff_t'(a);
    return gn3_pkg::lprod_t'(signed'({1'b0, t})) * gn3_pkg::lprod_t'(d);
  endfunction

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      l1_nxt[i] = la6_r[i] + gn3_pkg::grad_t'(lp6_r[i] >>> gn3_pkg::F);
    end
    for (int j = 0; j < 2; j++) begin
      m_nxt[j] = ma7_r[j] + gn3_pkg::grad_t'(mp7_r[j] >>> gn3_pkg::F);
    end
    r_nxt  = za8_r + gn3_pkg::grad_t'(zp8_r >>> gn3_pkg::F);
    q_nxt  = r_nxt + gn3_pkg::grad_t'(gn3_pkg::OFS_ONE);
    // clamp below zero, then scale (r+1)/2 into q0.16
    sc_nxt = q_nxt[gn3_pkg::F+2] ? '0
             : (QW'({q_nxt, 16'h0000}) >> (gn3_pkg::F + 1));
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[6]) begin
      for (int i = 0; i < 4; i++) begin
        la6_r[i] <= grad_s5[2*i];
        lp6_r[i] <= lmul(u_s5, grad_s5[2*i], grad_s5[2*i+1]);
      end
      v6_r <= v_s5;
      w6_r <= w_s5;
    end
    if (ctl.adv[7]) begin
      for (int j = 0; j < 2; j++) begin
        ma7_r[j] <= l1_nxt[2*j];
        mp7_r[j] <= lmul(v6_r, l1_nxt[2*j], l1_nxt[2*j+1]);
      end
      w7_r <= w6_r;
    end
    if (ctl.adv[8]) begin
      za8_r <= m_nxt[0];
      zp8_r <= lmul(w7_r, m_nxt[0], m_nxt[1]);
    end
    if (ctl.adv[9]) begin
      noise9_r <= (sc_nxt > QW'(16'hFFFF)) ? 16'hFFFF : sc_nxt[15:0];
    end
  end

  assign noise_s9 = noise9_r;

endmodule

### design/gradient_noise_3d_top.sv
// ----------------------------------------------------------------------------
// gradient_noise_3d_top
// Improved 3d gradient noise on q16.16 points, nine stage pipeline.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                      | tuser
//  in_     | in  | load_index, load_value, coord_x/y/z (112b) | op
//  out_    | out | noise_value (16b)                          | -
//
// one beat per cycle while the pipeline is not stalled; an evaluate beat passes
// stages 1 to 9 and its result is registered in stage 9, a load beat writes
// the table copies as it passes stages 1 to 3 and leaves the pipeline after
// stage 4. each stage holds while the stage after it is full and stalled,
// so bubbles are squeezed out under out_tready low. synchronous reset clears
// the valid bits only; the table is undefined until loaded.
// ----------------------------------------------------------------------------
module gradient_noise_3d_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // load_index, load_value, coord_x, coord_y, coord_z
  input  logic         in_tuser,   // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata   // noise_value
);

  localparam int N = gn3_pkg::NST;
  localparam int F = gn3_pkg::F;

  logic [N:1]          v_r;
  logic [N:1]          rdy;
  gn3_pkg::stage_ctl_t ctl;

  gn3_pkg::frac_t  tx4, ty4, tz4;
  gn3_pkg::fade_t  u5, v5, w5;
  logic            op4;
  logic [7:0][3:0] h4;
  gn3_pkg::grad_t  g5_r [8];
  gn3_pkg::ofs_t   x0, y0, z0, x1, y1, z1;

  always_comb begin
    rdy[N] = !v_r[N] || out_tready;
    for (int k = N - 1; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    ctl.adv = rdy;
    ctl.vld = v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= N; k++) begin
        if (rdy[k]) begin
          if (k == 1) v_r[k] <= in_tvalid;
          else if (k == 5) v_r[k] <= v_r[4] && (op4 == gn3_pkg::OP_EVAL);
          else v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  gn3_hash u_hash (
    .clk     (clk),
    .ctl     (ctl),
    .op_in   (in_tuser),
    .ld_idx  (in_tdata[7:0]),
    .ld_val  (in_tdata[15:8]),
    .cell_x  (in_tdata[16+F+7:16+F]),
    .cell_y  (in_tdata[48+F+7:48+F]),
    .cell_z  (in_tdata[80+F+7:80+F]),
    .op_s4   (op4),
    .hash_s4 (h4)
  );

  gn3_fade u_fade_x (.clk(clk), .ctl(ctl), .t_in(in_tdata[16+F-1:16]),
                     .t_s4(tx4), .fade_s5(u5));
  gn3_fade u_fade_y (.clk(clk), .ctl(ctl), .t_in(in_tdata[48+F-1:48]),
                     .t_s4(ty4), .fade_s5(v5));
  gn3_fade u_fade_z (.clk(clk), .ctl(ctl), .t_in(in_tdata[80+F-1:80]),
                     .t_s4(tz4), .fade_s5(w5));

  always_comb begin
    x0 = gn3_pkg::ofs_t'({2'b00, tx4});
    y0 = gn3_pkg::ofs_t'({2'b00, ty4});
    z0 = gn3_pkg::ofs_t'({2'b00, tz4});
    x1 = x0 - gn3_pkg::OFS_ONE;
    y1 = y0 - gn3_pkg::OFS_ONE;
    z1 = z0 - gn3_pkg::OFS_ONE;
  end

  // corner order: x then y then z, low corner first
  always_ff @(posedge clk) begin
    if (ctl.adv[5]) begin
      g5_r[0] <= gn3_pkg::corner_dot(h4[0], x0, y0, z0);
      g5_r[1] <= gn3_pkg::corner_dot(h4[1], x1, y0, z0);
      g5_r[2] <= gn3_pkg::corner_dot(h4[2], x0, y1, z0);
      g5_r[3] <= gn3_pkg::corner_dot(h4[3], x1, y1, z0);
      g5_r[4] <= gn3_pkg::corner_dot(h4[4], x0, y0, z1);
      g5_r[5] <= gn3_pkg::corner_dot(h4[5], x1, y0, z1);
      g5_r[6] <= gn3_pkg::corner_dot(h4[6], x0, y1, z1);
      g5_r[7] <= gn3_pkg::corner_dot(h4[7], x1, y1, z1);
    end
  end

  gn3_interp u_interp (
    .clk      (clk),
    .ctl      (ctl),
    .grad_s5  (g5_r),
    .u_s5     (u5),
    .v_s5     (v5),
    .w_s5     (w5),
    .noise_s9 (out_tdata)
  );

  assign in_tready  = rdy[1];
  assign out_tvalid = v_r[N];

  a_load_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy[5] && v_r[4] && (op4 == gn3_pkg::OP_LOAD)) |=> !v_r[5])
    else $error("load beat reached the arithmetic stages");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r))
    else $error("input held off with a bubble in the pipeline");

  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_tvalid) |-> $past(out_tready))
    else $error("result dropped without being taken");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the 3d gradient noise pipeline: loads the permutation table,
// streams directed and random points under several idling patterns and
// checks every noise value against a fixed point predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int     FB  = gn3_pkg::F;
  localparam longint ONE = longint'(1) << FB;

  typedef struct {
    gn3_pkg::op_t op;
    logic [7:0]   idx;
    logic [7:0]   val;
    logic [31:0]  cx;
    logic [31:0]  cy;
    logic [31:0]  cz;
  } beat_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;   // load_index, load_value, coord_x, coord_y, coord_z
  logic         in_tuser;   // op
  logic         out_tvalid;
  logic         out_tready;
  logic [15:0]  out_tdata;  // noise_value

  gradient_noise_3d_top u_top (.*);

  beat_t       pending_beats[$];
  beat_t       cur_beat;
  logic [15:0] expected_noise[$];
  logic [7:0]  perm_copy[256];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;
  logic        hold_start;
  int          err_cnt;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint fade(longint t);
    longint p;
    p = 10 * ONE - ((t * (15 * ONE - 6 * t)) >> FB);
    p = (p * t) >> FB;
    p = (p * t) >> FB;
    p = (p * t) >> FB;
    return p;
  endfunction

  function automatic longint lerp(longint t, longint a, longint b);
    return a + ((t * (b - a)) >>> FB);
  endfunction

  function automatic longint grad(int unsigned hv, longint x, longint y, longint z);
    int unsigned h;
    longint      u;
    longint      v;
    h = hv & 15;
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
  endfunction

  function automatic int unsigned perm(int unsigned i);
    return perm_copy[i & 255];
  endfunction

  function automatic logic [15:0] noise_at(beat_t b);
    int unsigned ix, iy, iz, a, aa, ab, bx, ba, bb;
    longint      x, y, z, x1, y1, z1, u, v, w, r, q;
    ix = b.cx[23:16];
    iy = b.cy[23:16];
    iz = b.cz[23:16];
    x = b.cx[15:0];
    y = b.cy[15:0];
    z = b.cz[15:0];
    x1 = x - ONE;
    y1 = y - ONE;
    z1 = z - ONE;
    u = fade(x);
    v = fade(y);
    w = fade(z);
    a  = perm(ix) + iy;
    aa = perm(a) + iz;
    ab = perm(a + 1) + iz;
    bx = perm(ix + 1) + iy;
    ba = perm(bx) + iz;
    bb = perm(bx + 1) + iz;
    r = lerp(w,
          lerp(v, lerp(u, grad(perm(aa), x, y, z), grad(perm(ba), x1, y, z)),
                  lerp(u, grad(perm(ab), x, y1, z), grad(perm(bb), x1, y1, z))),
          lerp(v, lerp(u, grad(perm(aa + 1), x, y, z1), grad(perm(ba + 1), x1, y, z1)),
                  lerp(u, grad(perm(ab + 1), x, y1, z1),
                          grad(perm(bb + 1), x1, y1, z1))));
    q = r + ONE;
    if (q < 0) q = 0;
    q = q >> 1;
    if (q > 65535) q = 65535;
    return q[15:0];
  endfunction

  // ------------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (cur_beat.op == gn3_pkg::OP_LOAD) perm_copy[cur_beat.idx] = cur_beat.val;
        else expected_noise.push_back(noise_at(cur_beat));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_beat = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_beat.op;
          in_tdata  <= {cur_beat.cz, cur_beat.cy, cur_beat.cx, cur_beat.val, cur_beat.idx};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) hold_cycles <= 0;
    else if (hold_start) hold_cycles <= 300;
    else if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
  end

  // ------------------------------------------------------------------ monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_noise.size() == 0) begin
          $error("unexpected beat: noise_value actual %0d", out_tdata);
          err_cnt++;
        end else begin
          logic [15:0] exp_v;
          exp_v = expected_noise.pop_front();
          if (out_tdata !== exp_v) begin
            $error("noise_value expected %0d actual %0d", exp_v, out_tdata);
            err_cnt++;
          end
        end
      end
      out_tready <= (hold_cycles == 0 && !hold_start) && $urandom_range(99) >= recv_stall_pct;
    end
  end

  // ----------------------------------------------------------------- stimulus
  function automatic beat_t eval_beat(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    beat_t b;
    b.op = gn3_pkg::OP_EVAL; b.idx = 8'($urandom); b.val = 8'($urandom);
    b.cx = x; b.cy = y; b.cz = z;
    return b;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(32'h00FF_FFFF);
      2:       return -$urandom_range(32'h00FF_FFFF);
      default: return {$urandom_range(7) == 0 ? 16'hFFFF : 16'($urandom_range(3)),
                       16'($urandom)};
    endcase
  endfunction

  task automatic add_random(int n);
    beat_t b;
    repeat (n) begin
      if ($urandom_range(99) < 25) begin
        b = eval_beat($urandom, $urandom, $urandom);
        b.op = gn3_pkg::OP_LOAD;
      end else begin
        b = eval_beat(rand_coord(), rand_coord(), rand_coord());
      end
      pending_beats.push_back(b);
    end
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || in_tvalid || expected_noise.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    beat_t      b;
    logic [7:0] shuffle[256];
    int         j;
    logic [7:0] t;
    err_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_start = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // whole table first, so no evaluation reads an unwritten entry
    for (int i = 0; i < 256; i++) shuffle[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = int'($urandom_range(i));
      t = shuffle[i]; shuffle[i] = shuffle[j]; shuffle[j] = t;
    end
    for (int i = 0; i < 256; i++) begin
      b = eval_beat(0, 0, 0);
      b.op = gn3_pkg::OP_LOAD; b.idx = 8'(i); b.val = shuffle[i];
      pending_beats.push_back(b);
    end

    // directed points (extremes, cell wrap, fractions at both ends) and two table entry reloads
    pending_beats.push_back(eval_beat(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    pending_beats.push_back(eval_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_beats.push_back(eval_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_beats.push_back(eval_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_beats.push_back(eval_beat(32'h0000_FFFF, 32'h0000_0001, 32'h0000_8000));
    pending_beats.push_back(eval_beat(32'h00FF_8000, 32'h00FF_4000, 32'h00FF_C000));
    pending_beats.push_back(eval_beat(32'h0001_0000, 32'hFFFF_0000, 32'h0080_0000));
    pending_beats.push_back(eval_beat(32'h0003_8000, 32'h0005_8000, 32'h0007_8000));
    pending_beats.push_back(eval_beat(32'hFF80_2000, 32'h1234_5678, 32'hDEAD_BEEF));
    b = eval_beat(0, 0, 0); b.op = gn3_pkg::OP_LOAD; b.idx = 8'hFF; b.val = 8'h00;
    pending_beats.push_back(b);
    b.idx = 8'h00; b.val = 8'hFF;
    pending_beats.push_back(b);
    pending_beats.push_back(eval_beat(32'h00FF_FFFF, 32'h0000_0000, 32'h00FF_0000));
    pending_beats.push_back(eval_beat(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
    drain();

    // no idling, with a long receiver hold so the pipeline backs up
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    add_random(60);
    drain();

    send_idle_pct = 88;
    add_random(60);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 88;
    add_random(60);
    drain();

    send_idle_pct = 11;
    recv_stall_pct = 11;
    add_random(60);
    drain();

    repeat (30) @(posedge clk);
    if (err_cnt == 0 && expected_noise.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### gradient_noise_3d_top.f
design/gn3_pkg.sv
design/gn3_fade.sv
design/gn3_hash.sv
design/gn3_interp.sv
design/gradient_noise_3d_top.sv
tb/tb_top.sv
